[hdl/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// Shared widths, operation codes and status codes for the double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

   localparam int WORD_W        = 32;
   localparam int KIND_W        = 3;
   localparam int STATUS_W      = 2;
   localparam int DEPTH_DEFAULT = 16;

   // operation codes carried in the request tuser
   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LIST       = 3'd4;

   // result status codes carried in the response tuser
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

endpackage

`default_nettype wire

[hdl/dq_ring.sv]
// ----------------------------------------------------------------------------
// dq_ring
// Ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ring #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  wire                                clock,
   input  wire                                wr_en,
   input  wire  [$clog2(DEPTH)-1:0]           wr_addr,
   input  wire  signed [dq_pkg::WORD_W-1:0]   wr_data,
   input  wire                                rd_en,
   input  wire  [$clog2(DEPTH)-1:0]           rd_addr,
   output logic signed [dq_pkg::WORD_W-1:0]   rd_data
);

   logic signed [dq_pkg::WORD_W-1:0] mem_ff [DEPTH];
   logic signed [dq_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed words in a ring memory with front pointer and count.
// ----------------------------------------------------------------------------
// A single result waits in S_EMIT, and the first listed element in S_LIST,
//   until the output register is free (the ring read of a pop or listing
//   overlaps accept). Requests are taken only in S_IDLE, so a new item waits
//   until the last result is loaded; a listing streams its elements from the
//   single read port. Unused kind codes are accepted and dropped without a result.
// Reset (synchronous, active high) empties the queue; ring contents are kept.
`default_nettype none

module double_ended_queue #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   // request channel
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  signed [dq_pkg::WORD_W-1:0]   req_tdata,   // [31:0] value
   input  wire  [dq_pkg::KIND_W-1:0]          req_tuser,   // [2:0] kind
   // response channel
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic signed [dq_pkg::WORD_W-1:0]   rsp_tdata,   // [31:0] element
   output logic [dq_pkg::STATUS_W-1:0]        rsp_tuser,   // [1:0] status
   output logic                               rsp_tlast
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EMIT = 2'd1;   // single result pending
   localparam logic [1:0] S_LIST = 2'd2;   // streaming a listing

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;           // listing position being output
   logic [dq_pkg::STATUS_W-1:0] pend_stat_ff, pend_stat_in;
   logic             sel_mem_ff, sel_mem_in;   // pending element comes from ring

   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [dq_pkg::WORD_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [dq_pkg::STATUS_W-1:0]       rsp_user_ff, rsp_user_in;
   logic                              rsp_last_ff, rsp_last_in;

   // ring port
   logic                              wr_en, rd_en;
   logic [IDX_W-1:0]                  slot_addr;
   logic signed [dq_pkg::WORD_W-1:0]  rd_data;

   // address path
   logic [CNT_W-1:0] offset;
   logic [SUM_W-1:0] slot_sum;
   logic [SUM_W-1:0] slot_wrap;
   logic [IDX_W-1:0] front_next;
   logic [CNT_W-1:0] lst_next;
   logic             out_free;
   logic             req_acc;
   logic             is_full, is_empty;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign is_full    = (count_ff == CNT_W'(DEPTH));
   assign is_empty   = (count_ff == '0);
   assign lst_next   = CNT_W'(idx_ff) + CNT_W'(1);

   // offset from the front for the one ring access of this cycle
   always_comb begin
      offset = '0;
      if (state_ff == S_LIST) begin
         offset = lst_next;
      end else begin
         unique case (req_tuser)
            dq_pkg::KIND_PUSH_FRONT: offset = CNT_W'(DEPTH - 1);
            dq_pkg::KIND_PUSH_BACK:  offset = count_ff;
            dq_pkg::KIND_POP_BACK:   offset = count_ff - CNT_W'(1);
            default:                 offset = '0;
         endcase
      end
   end

   // (front + offset) mod DEPTH; sum stays below 2*DEPTH whenever the ring is accessed
   assign slot_sum  = SUM_W'(front_ff) + SUM_W'(offset);
   assign slot_wrap = (slot_sum >= SUM_W'(DEPTH)) ? (slot_sum - SUM_W'(DEPTH)) : slot_sum;
   assign slot_addr = slot_wrap[IDX_W-1:0];

   assign front_next = (front_ff == IDX_W'(DEPTH - 1)) ? '0 : (front_ff + IDX_W'(1));

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pend_stat_in = pend_stat_ff;
      sel_mem_in   = sel_mem_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               unique case (req_tuser)
                  dq_pkg::KIND_PUSH_FRONT, dq_pkg::KIND_PUSH_BACK: begin
                     sel_mem_in = 1'b0;
                     state_in   = S_EMIT;
                     if (is_full) begin
                        pend_stat_in = dq_pkg::STAT_FULL;
                     end else begin
                        pend_stat_in = dq_pkg::STAT_OK;
                        wr_en        = 1'b1;
                        count_in     = count_ff + CNT_W'(1);
                        if (req_tuser == dq_pkg::KIND_PUSH_FRONT) begin
                           front_in = slot_addr;
                        end
                     end
                  end
                  dq_pkg::KIND_POP_FRONT, dq_pkg::KIND_POP_BACK: begin
                     state_in = S_EMIT;
                     if (is_empty) begin
                        pend_stat_in = dq_pkg::STAT_EMPTY;
                        sel_mem_in   = 1'b0;
                     end else begin
                        pend_stat_in = dq_pkg::STAT_OK;
                        sel_mem_in   = 1'b1;
                        rd_en        = 1'b1;
                        count_in     = count_ff - CNT_W'(1);
                        if (req_tuser == dq_pkg::KIND_POP_FRONT) begin
                           front_in = front_next;
                        end
                     end
                  end
                  dq_pkg::KIND_LIST: begin
                     if (is_empty) begin
                        pend_stat_in = dq_pkg::STAT_EMPTY;
                        sel_mem_in   = 1'b0;
                        state_in     = S_EMIT;
                     end else begin
                        rd_en    = 1'b1;       // fetch the front element
                        idx_in   = '0;
                        state_in = S_LIST;
                     end
                  end
                  default: begin
                     // unused codes: dropped without a result
                  end
               endcase
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = pend_stat_ff;
               rsp_data_in  = sel_mem_ff ? rd_data : '0;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_LIST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = dq_pkg::STAT_OK;
               rsp_data_in  = rd_data;
               rsp_last_in  = (lst_next == count_ff);
               if (lst_next == count_ff) begin
                  state_in = S_IDLE;
               end else begin
                  // next element read overlaps the output load
                  rd_en  = 1'b1;
                  idx_in = lst_next[IDX_W-1:0];
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      pend_stat_ff <= pend_stat_in;
      sel_mem_ff   <= sel_mem_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
      rsp_last_ff  <= rsp_last_in;
   end

   dq_ring #(
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_addr),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (slot_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

[tb/dq_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dq_checker
// Watches both channels of the deque. Every accepted request item updates a
// private copy of the deque and queues the results it should produce. Every
// accepted response item is checked field by field against the oldest one.
// ----------------------------------------------------------------------------

module dq_checker #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_tvalid,
   input  wire                           req_tready,
   input  wire [dq_pkg::WORD_W-1:0]      req_tdata,   // [31:0] value
   input  wire [dq_pkg::KIND_W-1:0]      req_tuser,   // [2:0] kind
   input  wire                           rsp_tvalid,
   input  wire                           rsp_tready,
   input  wire [dq_pkg::WORD_W-1:0]      rsp_tdata,   // [31:0] element
   input  wire [dq_pkg::STATUS_W-1:0]    rsp_tuser,   // [1:0] status
   input  wire                           rsp_tlast,
   output int                            mismatch_count,
   output int                            pending_count,
   output int                            results_checked,
   output int                            refused_pushes,
   output int                            empty_answers,
   output int                            listed_words
);

   typedef struct packed {
      logic [dq_pkg::STATUS_W-1:0] status;
      logic [dq_pkg::WORD_W-1:0]   element;
      logic                        last;
   } dq_result_type;

   // mirror of the deque
   logic [dq_pkg::WORD_W-1:0] ring_mirror [DEPTH];
   int unsigned               head_slot;
   int unsigned               fill;

   dq_result_type             results_due [$];

   function automatic dq_result_type make_result(input logic [dq_pkg::STATUS_W-1:0] status,
                                                 input logic [dq_pkg::WORD_W-1:0] element,
                                                 input logic last);
      dq_result_type r;
      r.status  = status;
      r.element = element;
      r.last    = last;
      return r;
   endfunction

   // Applies one operation to the mirror and queues what it must answer.
   task automatic model_deque_op(input logic [dq_pkg::KIND_W-1:0] kind,
                                 input logic [dq_pkg::WORD_W-1:0] value);
      int unsigned i;
      int unsigned slot;
      case (kind)
         dq_pkg::KIND_PUSH_FRONT, dq_pkg::KIND_PUSH_BACK: begin
            if (fill >= DEPTH) begin
               results_due.push_back(make_result(dq_pkg::STAT_FULL, '0, 1'b1));
            end else begin
               if (kind == dq_pkg::KIND_PUSH_FRONT) begin
                  head_slot = (head_slot + DEPTH - 1) % DEPTH;
                  ring_mirror[head_slot] = value;
               end else begin
                  ring_mirror[(head_slot + fill) % DEPTH] = value;
               end
               fill++;
               results_due.push_back(make_result(dq_pkg::STAT_OK, '0, 1'b1));
            end
         end
         dq_pkg::KIND_POP_FRONT, dq_pkg::KIND_POP_BACK: begin
            if (fill == 0) begin
               results_due.push_back(make_result(dq_pkg::STAT_EMPTY, '0, 1'b1));
            end else begin
               if (kind == dq_pkg::KIND_POP_FRONT) begin
                  slot      = head_slot;
                  head_slot = (head_slot + 1) % DEPTH;
               end else begin
                  slot = (head_slot + fill - 1) % DEPTH;
               end
               fill--;
               results_due.push_back(make_result(dq_pkg::STAT_OK, ring_mirror[slot], 1'b1));
            end
         end
         dq_pkg::KIND_LIST: begin
            if (fill == 0) begin
               results_due.push_back(make_result(dq_pkg::STAT_EMPTY, '0, 1'b1));
            end else begin
               for (i = 0; i < fill; i++)
                  results_due.push_back(make_result(dq_pkg::STAT_OK,
                     ring_mirror[(head_slot + i) % DEPTH], (i + 1 == fill)));
            end
         end
         default: ;  // spare codes: dropped, no answer
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [dq_pkg::WORD_W-1:0] got,
                                  input logic [dq_pkg::WORD_W-1:0] want);
      $display("%0t ns: result %0d, %s: got %h, want %h",
               $time, results_checked, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      dq_result_type want;
      if (reset) begin
         head_slot = 0;
         fill      = 0;
         results_due.delete();
         pending_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            model_deque_op(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               report_mismatch("unexpected item", rsp_tdata, '0);
            end else begin
               want = results_due.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("status", dq_pkg::WORD_W'(rsp_tuser),
                                  dq_pkg::WORD_W'(want.status));
               if (rsp_tdata !== want.element)
                  report_mismatch("element", rsp_tdata, want.element);
               if (rsp_tlast !== want.last)
                  report_mismatch("last", dq_pkg::WORD_W'(rsp_tlast),
                                  dq_pkg::WORD_W'(want.last));
               if (want.status == dq_pkg::STAT_FULL)  refused_pushes++;
               if (want.status == dq_pkg::STAT_EMPTY) empty_answers++;
            end
            if (rsp_tuser === dq_pkg::STAT_OK && rsp_tlast === 1'b0) listed_words++;
            results_checked++;
         end
         pending_count <= results_due.size();
      end
   end

endmodule

[tb/tb_double_ended_queue.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Drives operations into the deque with random gaps and random response
// backpressure. Directed cases first, then fill, drain and mixed sequences.
// The checker beside the DUT predicts and compares; this module only makes
// stimulus and gives the verdict.
// ----------------------------------------------------------------------------

module tb_double_ended_queue;

   localparam int DEPTH       = dq_pkg::DEPTH_DEFAULT;
   localparam int ITEMS       = 430;      // counted operations (spare codes excluded)
   localparam int QUIET_ITEMS = 60;       // last stretch runs without idling
   localparam int CYCLE_LIMIT = 600000;   // several times the slowest legal run
   localparam int TAIL_CYCLES = 40;       // DUT drains a dropped item without a result

   // codes outside the operation set; the DUT must swallow them silently
   localparam logic [dq_pkg::KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [dq_pkg::KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

   localparam logic [dq_pkg::WORD_W-1:0] WORD_MAX_POS = 32'h7FFF_FFFF;
   localparam logic [dq_pkg::WORD_W-1:0] WORD_MIN_NEG = 32'h8000_0000;
   localparam logic [dq_pkg::WORD_W-1:0] WORD_ONES    = 32'hFFFF_FFFF;

   logic                         clock;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [dq_pkg::WORD_W-1:0]    req_tdata  = '0;   // [31:0] value
   logic [dq_pkg::KIND_W-1:0]    req_tuser  = '0;   // [2:0] kind
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [dq_pkg::WORD_W-1:0]    rsp_tdata;         // [31:0] element
   logic [dq_pkg::STATUS_W-1:0]  rsp_tuser;         // [1:0] status
   logic                         rsp_tlast;

   int mismatch_count, pending_count, results_checked;
   int refused_pushes, empty_answers, listed_words;
   int cycle_count = 0;
   int ops_sent    = 0;
   bit quiet       = 1'b0;   // set for the final stretch: no gaps, no stalls

   double_ended_queue #(.DEPTH(DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   dq_checker #(.DEPTH(DEPTH)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count),
      .results_checked (results_checked),
      .refused_pushes  (refused_pushes),
      .empty_answers   (empty_answers),
      .listed_words    (listed_words)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog. A result that never shows up also ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Watchdog: no completion after %0d cycles, %0d results still due",
                  cycle_count, pending_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Response side: ready in random runs, stalled in random bursts.
   // Long ready runs give stretches with no stalls at all.
   initial begin : rsp_side
      int n;
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 14);
            rsp_tready <= 1'b0;
         end else begin
            n = $urandom_range(1, 30);
            rsp_tready <= 1'b1;
         end
         repeat (n) @(posedge clock);
      end
   end

   // Mostly random words, with the signed extremes mixed in now and then.
   function automatic logic [dq_pkg::WORD_W-1:0] pick_word();
      case ($urandom_range(0, 11))
         0:       return WORD_MAX_POS;
         1:       return WORD_MIN_NEG;
         2:       return '0;
         3:       return WORD_ONES;
         default: return $urandom;
      endcase
   endfunction

   // Presents one item and returns at the edge where it is taken. tvalid is
   // left high; the next call or a pause lowers it, never in the same step.
   task automatic send_item(input logic [dq_pkg::KIND_W-1:0] kind,
                            input logic [dq_pkg::WORD_W-1:0] value);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 4) == 0)
         gap = $urandom_range(1, 14);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind <= dq_pkg::KIND_LIST) ops_sent++;
   endtask

   // Stop sending until every predicted result has been taken. The checker
   // publishes its count through a register, hence the extra edge first.
   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic push_any(input int n);
      repeat (n)
         send_item(dq_pkg::KIND_W'($urandom_range(dq_pkg::KIND_PUSH_FRONT,
                                                  dq_pkg::KIND_PUSH_BACK)), pick_word());
   endtask

   task automatic pop_any(input int n);
      repeat (n)
         send_item(dq_pkg::KIND_W'($urandom_range(dq_pkg::KIND_POP_FRONT,
                                                  dq_pkg::KIND_POP_BACK)), $urandom);
   endtask

   initial begin : stimulus
      int  r;
      bit  paused_mid;
      paused_mid = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // empty queue: both pops and a listing answer "empty"
      send_item(dq_pkg::KIND_POP_FRONT, WORD_ONES);
      send_item(dq_pkg::KIND_POP_BACK,  WORD_ONES);
      send_item(dq_pkg::KIND_LIST,      WORD_ONES);
      // extremes pushed at both ends, then listed front to back
      send_item(dq_pkg::KIND_PUSH_FRONT, WORD_MAX_POS);
      send_item(dq_pkg::KIND_PUSH_BACK,  WORD_MIN_NEG);
      send_item(dq_pkg::KIND_PUSH_FRONT, '0);
      send_item(dq_pkg::KIND_PUSH_BACK,  WORD_ONES);
      send_item(dq_pkg::KIND_LIST,       '0);
      send_item(dq_pkg::KIND_POP_BACK,   '0);
      send_item(dq_pkg::KIND_POP_FRONT,  '0);
      // spare codes must change nothing
      send_item(KIND_SPARE_FIRST,         WORD_ONES);
      send_item(KIND_SPARE_FIRST + 3'd1,  WORD_MIN_NEG);
      send_item(KIND_SPARE_LAST,          WORD_MAX_POS);
      send_item(dq_pkg::KIND_LIST,        '0);
      // down to empty again, then once more past the end
      send_item(dq_pkg::KIND_POP_FRONT, '0);
      send_item(dq_pkg::KIND_POP_BACK,  '0);
      send_item(dq_pkg::KIND_POP_BACK,  '0);

      // sender holds off until the DUT has answered everything
      wait_until_drained();

      // --- random sequences ---
      while (ops_sent < ITEMS) begin
         if (ops_sent >= ITEMS - QUIET_ITEMS) quiet = 1'b1;
         if (!paused_mid && ops_sent >= ITEMS / 2) begin
            wait_until_drained();
            paused_mid = 1'b1;
         end
         r = $urandom_range(0, 9);
         if (r < 2) begin
            // fill past capacity: the surplus pushes are refused, the list is full
            push_any(DEPTH + $urandom_range(1, 3));
            send_item(dq_pkg::KIND_LIST, $urandom);
         end else if (r < 4) begin
            // drain past empty, then list the empty queue
            pop_any(DEPTH + $urandom_range(1, 3));
            send_item(dq_pkg::KIND_LIST, $urandom);
         end else if (r < 9) begin
            // mixed traffic, pushes and pops balanced so the fill wanders
            repeat (12) begin
               r = $urandom_range(0, 19);
               if (r < 8)       push_any(1);
               else if (r < 16) pop_any(1);
               else if (r < 18) send_item(dq_pkg::KIND_LIST, $urandom);
               else send_item(dq_pkg::KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)),
                              $urandom);
            end
         end else begin
            // a short run of spare codes
            repeat ($urandom_range(1, 3))
               send_item(dq_pkg::KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)),
                         $urandom);
         end
      end

      wait_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d operations; %0d results checked, %0d listed words not final.",
               ops_sent, results_checked, listed_words);
      $display("Full-queue refusals: %0d, empty answers: %0d, mismatches: %0d.",
               refused_pushes, empty_answers, mismatch_count);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[double_ended_queue.f]
hdl/dq_pkg.sv
hdl/dq_ring.sv
hdl/double_ended_queue.sv
tb/dq_checker.sv
tb/tb_double_ended_queue.sv
